// File: hdl/fpa_pkg.sv
// Shared constants for the fixed-point ALU: opcodes, word width, default format.
// No dependencies.
package fpa_pkg;

  localparam int WORD_W        = 32;
  localparam int OP_W          = 4;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_MIN = 4'd4;
  localparam logic [OP_W-1:0] OP_MAX = 4'd5;
  localparam logic [OP_W-1:0] OP_I2F = 4'd6;
  localparam logic [OP_W-1:0] OP_F2I = 4'd7;
  localparam logic [OP_W-1:0] OP_INC = 4'd8;
  localparam logic [OP_W-1:0] OP_DEC = 4'd9;

endpackage

// File: hdl/fixed_point_alu_core.sv
// Fixed-point ALU, signed 32-bit words with FRAC_BITS fraction bits.
// Fully pipelined: one beat may enter every cycle unless the output is stalled,
// and each beat passes the input register, the setup stage, the divider stages
// and the output register, whatever the opcode. The divider is a restoring
// array that retires two quotient bits per stage; the multiplier takes one
// stage. A stalled output holds the whole pipeline in place.
// Depends on fpa_pkg.
module fixed_point_alu_core
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          req_type,
  input  logic signed [WORD_W-1:0] operand_a,
  input  logic signed [WORD_W-1:0] operand_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] result_value,
  output logic                     a_greater,
  output logic                     a_less,
  output logic                     a_equal,
  output logic                     div_zero_error
);

  localparam int DW = WORD_W + FRAC_BITS;   // dividend width
  localparam int NS = (DW + 1) / 2;         // divider stages, two bits each
  localparam int QW = 2 * NS;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // input register
  logic                     v0;
  logic [OP_W-1:0]          op0;
  logic signed [WORD_W-1:0] a0, b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      op0 <= req_type;
      a0  <= operand_a;
      b0  <= operand_b;
    end
  end

  // stage arrays: index 0 is the setup stage, 1..NS the divider
  logic                     v_s   [0:NS];
  logic [OP_W-1:0]          op_s  [0:NS];
  logic [WORD_W-1:0]        res_s [0:NS];
  logic                     gt_s  [0:NS];
  logic                     lt_s  [0:NS];
  logic                     eq_s  [0:NS];
  logic                     neg_s [0:NS];
  logic                     dz_s  [0:NS];
  logic [WORD_W-1:0]        mb_s  [0:NS];
  logic [WORD_W-1:0]        rem_s [0:NS];
  logic [QW-1:0]            quo_s [0:NS];
  logic signed [2*WORD_W-1:0] prod;

  // setup stage
  logic [WORD_W-1:0] simple_next, ma_next, mb_next;

  always_comb begin
    ma_next = a0[WORD_W-1] ? (~a0 + 1'b1) : a0;
    mb_next = b0[WORD_W-1] ? (~b0 + 1'b1) : b0;
    unique case (op0)
      OP_ADD:  simple_next = a0 + b0;
      OP_SUB:  simple_next = a0 - b0;
      OP_MIN:  simple_next = (a0 < b0) ? a0 : b0;
      OP_MAX:  simple_next = (a0 > b0) ? a0 : b0;
      OP_I2F:  simple_next = a0 << FRAC_BITS;
      OP_F2I:  simple_next = a0 >>> FRAC_BITS;
      OP_INC:  simple_next = a0 + 32'sd1;
      OP_DEC:  simple_next = a0 - 32'sd1;
      default: simple_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= v0;
    end
    if (en) begin
      op_s[0]  <= op0;
      res_s[0] <= simple_next;
      gt_s[0]  <= a0 > b0;
      lt_s[0]  <= a0 < b0;
      eq_s[0]  <= a0 == b0;
      neg_s[0] <= a0[WORD_W-1] ^ b0[WORD_W-1];
      dz_s[0]  <= (op0 == OP_DIV) && (b0 == '0);
      mb_s[0]  <= mb_next;
      rem_s[0] <= '0;
      quo_s[0] <= QW'({ma_next, {FRAC_BITS{1'b0}}});
      prod     <= a0 * b0;
    end
  end

  // divider stages
  for (genvar k = 1; k <= NS; k++) begin : g_div
    logic [WORD_W:0]   r1, r2;
    logic [QW-1:0]     q1, q2;
    logic [WORD_W-1:0] res_next;

    always_comb begin
      r1 = {rem_s[k-1], quo_s[k-1][QW-1]};
      q1 = {quo_s[k-1][QW-2:0], 1'b0};
      if (r1 >= {1'b0, mb_s[k-1]}) begin
        r1    = r1 - {1'b0, mb_s[k-1]};
        q1[0] = 1'b1;
      end
      r2 = {r1[WORD_W-1:0], q1[QW-1]};
      q2 = {q1[QW-2:0], 1'b0};
      if (r2 >= {1'b0, mb_s[k-1]}) begin
        r2    = r2 - {1'b0, mb_s[k-1]};
        q2[0] = 1'b1;
      end
    end

    if (k == 1) begin : g_mul
      logic signed [2*WORD_W-1:0] prod_sh;
      assign prod_sh  = prod >>> FRAC_BITS;
      assign res_next = (op_s[0] == OP_MUL) ? prod_sh[WORD_W-1:0] : res_s[0];
    end else begin : g_pass
      assign res_next = res_s[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else if (en) begin
        v_s[k] <= v_s[k-1];
      end
      if (en) begin
        op_s[k]  <= op_s[k-1];
        res_s[k] <= res_next;
        gt_s[k]  <= gt_s[k-1];
        lt_s[k]  <= lt_s[k-1];
        eq_s[k]  <= eq_s[k-1];
        neg_s[k] <= neg_s[k-1];
        dz_s[k]  <= dz_s[k-1];
        mb_s[k]  <= mb_s[k-1];
        rem_s[k] <= r2[WORD_W-1:0];
        quo_s[k] <= q2;
      end
    end
  end

  // output register
  logic [WORD_W-1:0] q32, final_next;

  always_comb begin
    q32 = quo_s[NS][WORD_W-1:0];
    if (op_s[NS] == OP_DIV) begin
      final_next = dz_s[NS] ? '0 : (neg_s[NS] ? (~q32 + 1'b1) : q32);
    end else begin
      final_next = res_s[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_s[NS];
    end
    if (en) begin
      result_value   <= final_next;
      a_greater      <= gt_s[NS];
      a_less         <= lt_s[NS];
      a_equal        <= eq_s[NS];
      div_zero_error <= dz_s[NS];
    end
  end

  // checks
  a_flags_onehot : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({a_greater, a_less, a_equal}))
    else $error("compare flags not one-hot");

  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero_error |-> result_value == '0)
    else $error("divide by zero with non-zero result");

  a_dz_neq : assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero_error && !a_equal |-> !(a_greater && a_less))
    else $error("flags inconsistent on divide by zero");

  a_stall_only : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule
